// ===== rtl/prrts_pkg.sv =====
`timescale 1ns / 1ps
// Package for the priority round-robin task scheduler.
// Holds the command and result structs, operation and status codes and default sizes.
package prrts_pkg;

	localparam int unsigned MaxTasksDefault  = 1024;
	localparam int unsigned NumLevelsDefault = 16;

	localparam logic [2:0] KIND_CREATE   = 3'd0;
	localparam logic [2:0] KIND_KILL     = 3'd1;
	localparam logic [2:0] KIND_ACTIVATE = 3'd2;
	localparam logic [2:0] KIND_SUSPEND  = 3'd3;
	localparam logic [2:0] KIND_SCHEDULE = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NONE     = 3'd1;
	localparam logic [2:0] ST_BAD_PRIO = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_REFUSED  = 3'd4;
	localparam logic [2:0] ST_UNKNOWN  = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic [9:0] task_id;
		logic [4:0] priority_req;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [9:0] result_id;
	} result_t;

endpackage

// ===== rtl/prrts_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module prrts_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/priority_round_robin_task_scheduler_top.sv =====
`timescale 1ns / 1ps
// Task scheduler: a task table in one RAM plus per-level FIFO queues linked through it.
// The id search reads one candidate at a time and unlinking walks the queue entry by entry,
// all reads going through the one RAM read port.
// Throughput: one command at a time; busy stays high up to and including the result strobe.
// Reset: after arst_n a clearing pass over all MAX_TASKS entries runs with busy high.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Depends on prrts_pkg and prrts_ram.
module priority_round_robin_task_scheduler_top #(
	parameter int unsigned MAX_TASKS  = prrts_pkg::MaxTasksDefault,
	parameter int unsigned NUM_LEVELS = prrts_pkg::NumLevelsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  prrts_pkg::cmd_t    cmd,
	output logic               done,
	output prrts_pkg::result_t result
);

	localparam int unsigned AW = $clog2(MAX_TASKS);
	localparam int unsigned LW = $clog2(NUM_LEVELS);
	// Record: used, in_queue, level, next link.
	localparam int unsigned RW     = 2 + LW + AW;
	localparam int unsigned B_USED = RW - 1;
	localparam int unsigned B_INQ  = RW - 2;
	localparam int unsigned B_LVL  = AW + LW - 1;

	typedef enum logic [12:0] {
		S_CLEAR     = 13'b0000000000001,
		S_IDLE      = 13'b0000000000010,
		S_SCH_HEAD  = 13'b0000000000100,
		S_RD_ID     = 13'b0000000001000,
		S_GET_ID    = 13'b0000000010000,
		S_WALK      = 13'b0000000100000,
		S_WALK_DATA = 13'b0000001000000,
		S_UNL_END   = 13'b0000010000000,
		S_APP       = 13'b0000100000000,
		S_TAIL_DATA = 13'b0001000000000,
		S_ID_WR     = 13'b0010000000000,
		S_SRCH_RD   = 13'b0100000000000,
		S_SRCH_CHK  = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic   done_q;

	logic [2:0]    op_q;
	logic [LW-1:0] prio_q;
	logic [AW-1:0] id_q, cur_q, prev_q, cand_q, cnt_q, last_q, clr_q;
	logic [RW-1:0] rec_q, prev_rec_q;
	logic [LW-1:0] lvl_q;
	logic          first_q;
	logic [2:0]    status_q;
	logic [AW-1:0] rid_q;

	logic [AW-1:0]   head_q [NUM_LEVELS];
	logic [AW-1:0]   tail_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] nonempty_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;

	prrts_ram #(.WIDTH(RW), .DEPTH(MAX_TASKS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Lowest-numbered non-empty level.
	logic [LW-1:0] top_lvl;
	always_comb begin
		top_lvl = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				top_lvl = LW'(i);
			end
		end
	end

	logic          tid_ok;
	logic          prio_ok;
	logic [AW-1:0] tid_idx;
	logic [AW-1:0] cand_next;
	logic [LW-1:0] rd_lvl;
	assign tid_ok    = {22'd0, cmd.task_id} < 32'(MAX_TASKS);
	assign prio_ok   = {27'd0, cmd.priority_req} < 32'(NUM_LEVELS);
	assign tid_idx   = AW'(cmd.task_id);
	assign cand_next = (cand_q == AW'(MAX_TASKS - 1)) ? '0 : cand_q + AW'(1);
	assign rd_lvl    = ram_rdata[B_LVL -: LW];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = id_q;
		ram_wdata = rec_q;
		ram_raddr = id_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_WALK: begin
				ram_raddr = cur_q;
				if (cur_q == id_q && !first_q) begin
					ram_we    = 1'b1;
					ram_waddr = prev_q;
					ram_wdata = {prev_rec_q[RW-1:AW], rec_q[AW-1:0]};
				end
			end
			S_APP:       ram_raddr = tail_q[lvl_q];
			S_TAIL_DATA: begin
				ram_we    = 1'b1;
				ram_waddr = tail_q[lvl_q];
				ram_wdata = {ram_rdata[RW-1:AW], id_q};
			end
			S_ID_WR:     ram_we = 1'b1;
			S_SRCH_RD:   ram_raddr = cand_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			done_q     <= 1'b0;
			clr_q      <= '0;
			last_q     <= AW'(MAX_TASKS - 1);
			nonempty_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_TASKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start && !done_q) begin
						op_q     <= cmd.kind;
						prio_q   <= LW'(cmd.priority_req);
						id_q     <= tid_idx;
						status_q <= prrts_pkg::ST_OK;
						rid_q    <= '0;
						unique case (cmd.kind)
							prrts_pkg::KIND_CREATE: begin
								if (!prio_ok) begin
									status_q <= prrts_pkg::ST_BAD_PRIO;
									done_q   <= 1'b1;
								end else begin
									cand_q  <= (last_q == AW'(MAX_TASKS - 1)) ? '0 : last_q + AW'(1);
									cnt_q   <= '0;
									state_q <= S_SRCH_RD;
								end
							end
							prrts_pkg::KIND_KILL: begin
								if (cmd.task_id == 10'd0) begin
									status_q <= prrts_pkg::ST_REFUSED;
									done_q   <= 1'b1;
								end else if (!tid_ok) begin
									status_q <= prrts_pkg::ST_UNKNOWN;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_RD_ID;
								end
							end
							prrts_pkg::KIND_ACTIVATE, prrts_pkg::KIND_SUSPEND: begin
								if (!tid_ok) begin
									status_q <= prrts_pkg::ST_UNKNOWN;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_RD_ID;
								end
							end
							prrts_pkg::KIND_SCHEDULE: begin
								if (nonempty_q == '0) begin
									status_q <= prrts_pkg::ST_NONE;
									done_q   <= 1'b1;
								end else begin
									lvl_q   <= top_lvl;
									state_q <= S_SCH_HEAD;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_SCH_HEAD: begin
					id_q    <= head_q[lvl_q];
					rid_q   <= head_q[lvl_q];
					state_q <= S_RD_ID;
				end
				S_RD_ID: state_q <= S_GET_ID;
				S_GET_ID: begin
					rec_q <= ram_rdata;
					lvl_q <= rd_lvl;
					if (op_q != prrts_pkg::KIND_SCHEDULE && !ram_rdata[B_USED]) begin
						status_q <= prrts_pkg::ST_UNKNOWN;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (ram_rdata[B_INQ] && nonempty_q[rd_lvl]) begin
						cur_q   <= head_q[rd_lvl];
						first_q <= 1'b1;
						state_q <= S_WALK;
					end else begin
						state_q <= S_UNL_END;
					end
				end
				S_WALK: begin
					if (cur_q == id_q) begin
						if (first_q) begin
							if (tail_q[lvl_q] == id_q) begin
								nonempty_q[lvl_q] <= 1'b0;
							end else begin
								head_q[lvl_q] <= rec_q[AW-1:0];
							end
						end else if (tail_q[lvl_q] == id_q) begin
							tail_q[lvl_q] <= prev_q;
						end
						state_q <= S_UNL_END;
					end else if (cur_q == tail_q[lvl_q]) begin
						state_q <= S_UNL_END;
					end else begin
						prev_q  <= cur_q;
						first_q <= 1'b0;
						state_q <= S_WALK_DATA;
					end
				end
				S_WALK_DATA: begin
					prev_rec_q <= ram_rdata;
					cur_q      <= ram_rdata[AW-1:0];
					state_q    <= S_WALK;
				end
				S_UNL_END: begin
					rec_q[B_INQ]  <= 1'b0;
					rec_q[AW-1:0] <= '0;
					if (op_q == prrts_pkg::KIND_KILL) begin
						rec_q[B_USED] <= 1'b0;
					end
					if (op_q == prrts_pkg::KIND_ACTIVATE || op_q == prrts_pkg::KIND_SCHEDULE) begin
						state_q <= S_APP;
					end else begin
						state_q <= S_ID_WR;
					end
				end
				S_APP: begin
					rec_q[B_INQ] <= 1'b1;
					if (nonempty_q[lvl_q]) begin
						state_q <= S_TAIL_DATA;
					end else begin
						head_q[lvl_q]     <= id_q;
						tail_q[lvl_q]     <= id_q;
						nonempty_q[lvl_q] <= 1'b1;
						state_q           <= S_ID_WR;
					end
				end
				S_TAIL_DATA: begin
					tail_q[lvl_q] <= id_q;
					state_q       <= S_ID_WR;
				end
				S_ID_WR: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SRCH_RD: state_q <= S_SRCH_CHK;
				S_SRCH_CHK: begin
					if (!ram_rdata[B_USED]) begin
						id_q    <= cand_q;
						last_q  <= cand_q;
						rid_q   <= cand_q;
						lvl_q   <= prio_q;
						rec_q   <= {1'b1, 1'b0, prio_q, {AW{1'b0}}};
						state_q <= S_APP;
					end else if (cnt_q == AW'(MAX_TASKS - 2)) begin
						status_q <= prrts_pkg::ST_FULL;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						cand_q  <= cand_next;
						cnt_q   <= cnt_q + AW'(1);
						state_q <= S_SRCH_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A command ending in the idle state still takes its strobe cycle there.
	assign busy             = (state_q != S_IDLE) || done_q;
	assign done             = done_q;
	assign result.status    = status_q;
	assign result.result_id = 10'(rid_q);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for priority_round_robin_task_scheduler_top.
// Holds its own model of the task table and the ready queues, fed from the prrts_pkg types.
// It runs a directed table, then random commands on a small table, a full table and a busy one.
module tb;

	localparam int NTASK = 1024;
	localparam int NLVL  = 16;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	prrts_pkg::cmd_t    cmd;
	logic               done;
	prrts_pkg::result_t result;

	priority_round_robin_task_scheduler_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	// Mirror of the scheduler state.
	bit         used_q [NTASK];
	logic [3:0] level_q [NTASK];
	logic [9:0] link_q [NTASK];
	bit         queued_q [NTASK];
	logic [9:0] head_q [NLVL];
	logic [9:0] tail_q [NLVL];
	bit         ready_q [NLVL];
	logic [9:0] last_id;
	int         live_tasks;

	prrts_pkg::result_t pending_results [$];
	int                 errors;
	int                 idle_pct;

	typedef struct {
		logic [2:0] kind;
		logic [9:0] tid;
		logic [4:0] prio;
		bit         typed;
		logic [2:0] status;
		logic [9:0] rid;
	} row_t;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("** priority_round_robin_task_scheduler_top: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void unlink_entry(input int id);
		int lv;
		int cur;
		int prev;
		bit first;
		lv = level_q[id];
		prev = 0;
		first = 1;
		if (!queued_q[id] || !ready_q[lv])
			return;
		cur = head_q[lv];
		for (int n = 0; n < NTASK; n++) begin
			if (cur == id) begin
				if (first) begin
					if (tail_q[lv] == id)
						ready_q[lv] = 0;
					else
						head_q[lv] = link_q[id];
				end else begin
					link_q[prev] = link_q[id];
					if (tail_q[lv] == id)
						tail_q[lv] = prev[9:0];
				end
				break;
			end
			if (cur == tail_q[lv])
				break;
			prev = cur;
			first = 0;
			cur = link_q[cur];
		end
		queued_q[id] = 0;
		link_q[id] = '0;
	endfunction

	function automatic void append_entry(input int id);
		int lv;
		lv = level_q[id];
		unlink_entry(id);
		link_q[id] = '0;
		if (ready_q[lv]) begin
			link_q[tail_q[lv]] = id[9:0];
			tail_q[lv] = id[9:0];
		end else begin
			head_q[lv] = id[9:0];
			tail_q[lv] = id[9:0];
			ready_q[lv] = 1;
		end
		queued_q[id] = 1;
	endfunction

	function automatic prrts_pkg::result_t predict_result(input prrts_pkg::cmd_t c);
		prrts_pkg::result_t r;
		int cand;
		bit found;
		bit known;
		r.status = prrts_pkg::ST_OK;
		r.result_id = '0;
		known = used_q[c.task_id];
		case (c.kind)
			prrts_pkg::KIND_CREATE: begin
				if (c.priority_req > NLVL - 1) begin
					r.status = prrts_pkg::ST_BAD_PRIO;
				end else begin
					cand = last_id;
					found = 0;
					for (int n = 0; n < NTASK - 1; n++) begin
						cand = (cand + 1 >= NTASK) ? 0 : cand + 1;
						if (!used_q[cand]) begin
							found = 1;
							break;
						end
					end
					if (!found) begin
						r.status = prrts_pkg::ST_FULL;
					end else begin
						last_id = cand[9:0];
						used_q[cand] = 1;
						live_tasks++;
						level_q[cand] = c.priority_req[3:0];
						queued_q[cand] = 0;
						link_q[cand] = '0;
						append_entry(cand);
						r.result_id = cand[9:0];
					end
				end
			end
			prrts_pkg::KIND_KILL: begin
				if (c.task_id == 0)
					r.status = prrts_pkg::ST_REFUSED;
				else if (!known)
					r.status = prrts_pkg::ST_UNKNOWN;
				else begin
					unlink_entry(c.task_id);
					used_q[c.task_id] = 0;
					live_tasks--;
				end
			end
			prrts_pkg::KIND_ACTIVATE: begin
				if (!known)
					r.status = prrts_pkg::ST_UNKNOWN;
				else
					append_entry(c.task_id);
			end
			prrts_pkg::KIND_SUSPEND: begin
				if (!known)
					r.status = prrts_pkg::ST_UNKNOWN;
				else
					unlink_entry(c.task_id);
			end
			prrts_pkg::KIND_SCHEDULE: begin
				r.status = prrts_pkg::ST_NONE;
				for (int lv = 0; lv < NLVL; lv++) begin
					if (ready_q[lv]) begin
						r.result_id = head_q[lv];
						append_entry(head_q[lv]);
						r.status = prrts_pkg::ST_OK;
						break;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// One command transfer; a typed expectation replaces the predicted one.
	task automatic issue_command(input prrts_pkg::cmd_t c, input bit typed,
		input prrts_pkg::result_t want);
		prrts_pkg::result_t r;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			cmd = prrts_pkg::cmd_t'($urandom);
			@(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		r = predict_result(c);
		pending_results.push_back(typed ? want : r);
	endtask

	function automatic logic [9:0] pick_live_id();
		int r;
		r = $urandom_range(NTASK - 1);
		for (int n = 0; n < NTASK; n++) begin
			if (used_q[(r + n) % NTASK])
				return 10'((r + n) % NTASK);
		end
		return 10'(r);
	endfunction

	function automatic prrts_pkg::cmd_t random_command(input int max_live);
		prrts_pkg::cmd_t c;
		int pick;
		pick = $urandom_range(99);
		if (pick < 28)
			c.kind = prrts_pkg::KIND_CREATE;
		else if (pick < 42)
			c.kind = prrts_pkg::KIND_KILL;
		else if (pick < 56)
			c.kind = prrts_pkg::KIND_ACTIVATE;
		else if (pick < 70)
			c.kind = prrts_pkg::KIND_SUSPEND;
		else if (pick < 95)
			c.kind = prrts_pkg::KIND_SCHEDULE;
		else
			c.kind = 3'($urandom_range(7, 5));
		if (c.kind == prrts_pkg::KIND_CREATE && live_tasks >= max_live)
			c.kind = prrts_pkg::KIND_KILL;
		c.task_id = ($urandom_range(99) < 80) ? pick_live_id() : 10'($urandom);
		c.priority_req = ($urandom_range(99) < 90) ? 5'($urandom_range(15))
			: 5'($urandom_range(31, 16));
		return c;
	endfunction

	task automatic random_phase(input int count, input int max_live);
		prrts_pkg::result_t none;
		none = '0;
		for (int i = 0; i < count; i++)
			issue_command(random_command(max_live), 1'b0, none);
	endtask

	always @(posedge clk) begin
		prrts_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", result.status, -1);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.result_id !== want.result_id)
					report_mismatch("result_id", result.result_id, want.result_id);
			end
		end
	end

	initial begin
		row_t               rows [$];
		prrts_pkg::cmd_t    c;
		prrts_pkg::result_t want;
		int                 waited;

		errors = 0;
		idle_pct = 0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		live_tasks = 0;
		last_id = 10'(NTASK - 1);
		for (int i = 0; i < NTASK; i++) begin
			used_q[i] = 0;
			queued_q[i] = 0;
		end
		for (int i = 0; i < NLVL; i++)
			ready_q[i] = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows = '{
			'{prrts_pkg::KIND_SCHEDULE, 10'd0, 5'd0, 1, prrts_pkg::ST_NONE, 10'd0},
			'{prrts_pkg::KIND_CREATE, 10'd0, 5'd16, 1, prrts_pkg::ST_BAD_PRIO, 10'd0},
			'{prrts_pkg::KIND_CREATE, 10'd1023, 5'd31, 1, prrts_pkg::ST_BAD_PRIO, 10'd0},
			'{prrts_pkg::KIND_KILL, 10'd0, 5'd0, 1, prrts_pkg::ST_REFUSED, 10'd0},
			'{prrts_pkg::KIND_KILL, 10'd1023, 5'd0, 1, prrts_pkg::ST_UNKNOWN, 10'd0},
			'{prrts_pkg::KIND_ACTIVATE, 10'd5, 5'd0, 1, prrts_pkg::ST_UNKNOWN, 10'd0},
			'{prrts_pkg::KIND_SUSPEND, 10'd1023, 5'd31, 1, prrts_pkg::ST_UNKNOWN, 10'd0},
			'{prrts_pkg::KIND_CREATE, 10'd0, 5'd0, 1, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_CREATE, 10'd0, 5'd15, 1, prrts_pkg::ST_OK, 10'd1},
			'{prrts_pkg::KIND_CREATE, 10'd0, 5'd15, 1, prrts_pkg::ST_OK, 10'd2},
			'{prrts_pkg::KIND_CREATE, 10'd0, 5'd7, 1, prrts_pkg::ST_OK, 10'd3},
			'{prrts_pkg::KIND_SCHEDULE, 10'd0, 5'd0, 1, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_SUSPEND, 10'd0, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_SCHEDULE, 10'd0, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_ACTIVATE, 10'd0, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_KILL, 10'd3, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_SCHEDULE, 10'd0, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_SUSPEND, 10'd0, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_SUSPEND, 10'd2, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_SUSPEND, 10'd2, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_KILL, 10'd2, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_SCHEDULE, 10'd0, 5'd0, 0, prrts_pkg::ST_OK, 10'd0},
			'{3'd5, 10'd1023, 5'd31, 1, prrts_pkg::ST_OK, 10'd0},
			'{3'd7, 10'd0, 5'd0, 1, prrts_pkg::ST_OK, 10'd0},
			'{prrts_pkg::KIND_SCHEDULE, 10'd0, 5'd0, 0, prrts_pkg::ST_OK, 10'd0}
		};
		foreach (rows[i]) begin
			c.kind = rows[i].kind;
			c.task_id = rows[i].tid;
			c.priority_req = rows[i].prio;
			want.status = rows[i].status;
			want.result_id = rows[i].rid;
			issue_command(c, rows[i].typed, want);
		end

		// Small table, so queues empty out and the scheduler often finds nothing ready.
		idle_pct = 51;
		random_phase(150, 24);
		idle_pct = 0;
		random_phase(50, 48);

		// Fill every slot, then show that two further creates find the table full.
		want = '0;
		while (live_tasks < NTASK) begin
			c.kind = prrts_pkg::KIND_CREATE;
			c.task_id = 10'($urandom);
			c.priority_req = 5'($urandom_range(15));
			issue_command(c, 1'b0, want);
		end
		c.priority_req = 5'd15;
		want.status = prrts_pkg::ST_FULL;
		issue_command(c, 1'b1, want);
		issue_command(c, 1'b1, want);

		// Near-full table with a free slot appearing now and then.
		idle_pct = 13;
		random_phase(90, NTASK);
		idle_pct = 51;
		random_phase(90, NTASK);

		// The last command is taken; drop start so it is not issued again.
		@(negedge clk);
		start = 1'b0;

		waited = 0;
		while (pending_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("** priority_round_robin_task_scheduler_top: PASSED **");
		else
			$display("** priority_round_robin_task_scheduler_top: FAILED **");
		$finish;
	end

endmodule
